[hw/rtl/bius_pkg.sv]
// shared constants, widths, register and opcode codes, divider handshake types
package bius_pkg;

	localparam int MAX_SMALL_WIDTH  = 64;
	localparam int MAX_SMALL_HEIGHT = 64;
	localparam int MAX_SCALE        = 16;

	localparam int COORD_W     = 10;
	localparam int PIX_W       = 8;
	localparam int SCALE_CFG_W = 5;
	localparam int SIZE_CFG_W  = 7;
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_INTERP = 1'b1;

	localparam logic [SCALE_CFG_W-1:0] SCALE_RESET  = 5'd2;
	localparam logic [SIZE_CFG_W-1:0]  WIDTH_RESET  = 7'd64;
	localparam logic [SIZE_CFG_W-1:0]  HEIGHT_RESET = 7'd64;

	localparam int SCALE_W = $clog2(MAX_SCALE + 1);
	localparam int XW      = $clog2(MAX_SMALL_WIDTH);
	localparam int YW      = $clog2(MAX_SMALL_HEIGHT);
	localparam int WCNT_W  = $clog2(MAX_SMALL_WIDTH + 1);
	localparam int HCNT_W  = $clog2(MAX_SMALL_HEIGHT + 1);
	localparam int DEPTH   = MAX_SMALL_WIDTH * MAX_SMALL_HEIGHT;
	localparam int ADDR_W  = $clog2(DEPTH);

	localparam int WT_W   = $clog2(MAX_SCALE * MAX_SCALE + 1);
	localparam int ACC_W  = $clog2(((1 << PIX_W) - 1) * MAX_SCALE * MAX_SCALE + 1);
	localparam int LIMX_W = $clog2(MAX_SMALL_WIDTH * MAX_SCALE + 1);
	localparam int LIMY_W = $clog2(MAX_SMALL_HEIGHT * MAX_SCALE + 1);
	localparam int LIM_W  = (LIMX_W > LIMY_W) ? LIMX_W : LIMY_W;
	localparam int CMP_W  = (LIM_W > COORD_W) ? LIM_W : COORD_W;

	localparam int DIV_N = (ACC_W > COORD_W) ? ACC_W : COORD_W;
	localparam int DIV_D = WT_W;
	localparam int DCNT_W = $clog2(DIV_N + 1);

	typedef struct packed {
		logic             start;
		logic [DIV_N-1:0] dividend;
		logic [DIV_D-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_N-1:0] quot;
		logic [DIV_D-1:0] remainder;
	} div_rsp_t;

endpackage

[hw/rtl/bilinear_image_upscale_core.sv]
// bilinear upscaler: small-image store, coordinate split, four-tap weighting, normalize
// sequence: a load goes straight to the output register; an interpolate passes the range check,
//   the col/row divide by scale, the store reads (one per tap, through one read port),
//   the pipeline drain, the divide by scale squared and then the output register
// flow: one item at a time, plus output stalls; no new item until the last is in the output register
// reset: arst_n clears control and restores scale 2, width 64, height 64; store is undefined
module bilinear_image_upscale_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bius_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bius_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  logic [bius_pkg::COORD_W-1:0]     col,
	input  logic [bius_pkg::COORD_W-1:0]     row,
	input  logic [bius_pkg::PIX_W-1:0]       pixel_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bius_pkg::PIX_W-1:0]       pixel_out,
	output logic                             out_of_range
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_NORM  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;

	logic [bius_pkg::SCALE_CFG_W-1:0] scale_q;
	logic [bius_pkg::SIZE_CFG_W-1:0]  width_q;
	logic [bius_pkg::SIZE_CFG_W-1:0]  height_q;

	logic [bius_pkg::SCALE_W-1:0] s_eff;
	logic [bius_pkg::WCNT_W-1:0]  w_eff;
	logic [bius_pkg::HCNT_W-1:0]  h_eff;

	logic [bius_pkg::COORD_W-1:0] col_q;
	logic [bius_pkg::COORD_W-1:0] row_q;
	logic [bius_pkg::XW-1:0]      x1_q;
	logic [bius_pkg::XW-1:0]      x2_q;
	logic [bius_pkg::YW-1:0]      y1_q;
	logic [bius_pkg::YW-1:0]      y2_q;
	logic [bius_pkg::SCALE_W-1:0] fx_q;
	logic [bius_pkg::SCALE_W-1:0] fy_q;
	logic [bius_pkg::SCALE_W-1:0] gx_q;
	logic [bius_pkg::SCALE_W-1:0] gy_q;
	logic [1:0]                   tap_q;

	logic [bius_pkg::PIX_W-1:0] res_pix_q;
	logic                       res_oor_q;
	logic [bius_pkg::PIX_W-1:0] out_pix_q;
	logic                       out_oor_q;
	logic                       out_valid_q;

	logic [bius_pkg::PIX_W-1:0] store_mem [bius_pkg::DEPTH];
	logic                       wr_en;
	logic [bius_pkg::ADDR_W-1:0] wr_addr;
	logic                       rd_en;
	logic [bius_pkg::ADDR_W-1:0] rd_addr;
	logic [bius_pkg::XW-1:0]    rd_x;
	logic [bius_pkg::YW-1:0]    rd_y;
	logic [bius_pkg::SCALE_W-1:0] wa;
	logic [bius_pkg::SCALE_W-1:0] wb;

	logic [bius_pkg::PIX_W-1:0] rd_data_s1;
	logic [bius_pkg::WT_W-1:0]  wt_s1;
	logic                       v_s1;
	logic [bius_pkg::ACC_W-1:0] prod_s2;
	logic                       v_s2;
	logic [bius_pkg::ACC_W-1:0] acc_q;

	logic in_acc;
	logic load_oob;
	logic interp_oob;
	logic drained;
	logic fin_move;
	logic [bius_pkg::CMP_W-1:0] lim_x;
	logic [bius_pkg::CMP_W-1:0] lim_y;
	logic [bius_pkg::WCNT_W-1:0] x1_inc;
	logic [bius_pkg::HCNT_W-1:0] y1_inc;
	logic [bius_pkg::XW-1:0]     x1_n;
	logic [bius_pkg::YW-1:0]     y1_n;

	bius_pkg::div_req_t div_x_req;
	bius_pkg::div_rsp_t div_x_rsp;
	bius_pkg::div_req_t div_y_req;
	bius_pkg::div_rsp_t div_y_rsp;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= bius_pkg::SCALE_RESET;
			width_q  <= bius_pkg::WIDTH_RESET;
			height_q <= bius_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bius_pkg::REG_SCALE:  scale_q  <= cfg_data[bius_pkg::SCALE_CFG_W-1:0];
				bius_pkg::REG_WIDTH:  width_q  <= cfg_data[bius_pkg::SIZE_CFG_W-1:0];
				bius_pkg::REG_HEIGHT: height_q <= cfg_data[bius_pkg::SIZE_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (scale_q == '0)
			s_eff = bius_pkg::SCALE_W'(1);
		else if (scale_q > bius_pkg::MAX_SCALE)
			s_eff = bius_pkg::SCALE_W'(bius_pkg::MAX_SCALE);
		else
			s_eff = bius_pkg::SCALE_W'(scale_q);
		if (width_q == '0)
			w_eff = bius_pkg::WCNT_W'(1);
		else if (width_q > bius_pkg::MAX_SMALL_WIDTH)
			w_eff = bius_pkg::WCNT_W'(bius_pkg::MAX_SMALL_WIDTH);
		else
			w_eff = bius_pkg::WCNT_W'(width_q);
		if (height_q == '0)
			h_eff = bius_pkg::HCNT_W'(1);
		else if (height_q > bius_pkg::MAX_SMALL_HEIGHT)
			h_eff = bius_pkg::HCNT_W'(bius_pkg::MAX_SMALL_HEIGHT);
		else
			h_eff = bius_pkg::HCNT_W'(height_q);
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign load_oob = (col >= bius_pkg::MAX_SMALL_WIDTH) || (row >= bius_pkg::MAX_SMALL_HEIGHT);
	assign wr_en    = in_acc && (opcode == bius_pkg::OP_LOAD) && !load_oob;
	assign wr_addr  = bius_pkg::ADDR_W'(row * bius_pkg::MAX_SMALL_WIDTH + col);

	assign lim_x = bius_pkg::CMP_W'(bius_pkg::CMP_W'(w_eff) * bius_pkg::CMP_W'(s_eff));
	assign lim_y = bius_pkg::CMP_W'(bius_pkg::CMP_W'(h_eff) * bius_pkg::CMP_W'(s_eff));
	assign interp_oob = (bius_pkg::CMP_W'(col_q) >= lim_x) || (bius_pkg::CMP_W'(row_q) >= lim_y);

	assign drained  = !v_s1 && !v_s2;
	assign fin_move = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// dividers: col and row by scale, then accumulator by scale squared
	always_comb begin
		div_x_req.start    = ((state_q == S_CHECK) && !interp_oob) ||
		                     ((state_q == S_DRAIN) && drained);
		div_y_req.start    = (state_q == S_CHECK) && !interp_oob;
		div_y_req.dividend = bius_pkg::DIV_N'(row_q);
		div_y_req.divisor  = bius_pkg::DIV_D'(s_eff);
		if (state_q == S_DRAIN) begin
			div_x_req.dividend = bius_pkg::DIV_N'(acc_q);
			div_x_req.divisor  = bius_pkg::DIV_D'(bius_pkg::DIV_D'(s_eff) *
			                                     bius_pkg::DIV_D'(s_eff));
		end else begin
			div_x_req.dividend = bius_pkg::DIV_N'(col_q);
			div_x_req.divisor  = bius_pkg::DIV_D'(s_eff);
		end
	end

	bius_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_x_req),
		.rsp    (div_x_rsp)
	);

	bius_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_y_req),
		.rsp    (div_y_rsp)
	);

	// neighbour index from the quotient, and the next index, which is clamped to the image in use
	assign x1_n   = div_x_rsp.quot[bius_pkg::XW-1:0];
	assign y1_n   = div_y_rsp.quot[bius_pkg::YW-1:0];
	assign x1_inc = bius_pkg::WCNT_W'(x1_n) + 1'b1;
	assign y1_inc = bius_pkg::HCNT_W'(y1_n) + 1'b1;

	// tap select
	always_comb begin
		case (tap_q)
			2'd0: begin rd_x = x1_q; rd_y = y1_q; wa = gx_q; wb = gy_q; end
			2'd1: begin rd_x = x2_q; rd_y = y1_q; wa = fx_q; wb = gy_q; end
			2'd2: begin rd_x = x1_q; rd_y = y2_q; wa = gx_q; wb = fy_q; end
			default: begin rd_x = x2_q; rd_y = y2_q; wa = fx_q; wb = fy_q; end
		endcase
	end

	assign rd_en   = (state_q == S_READ);
	assign rd_addr = bius_pkg::ADDR_W'(rd_y * bius_pkg::MAX_SMALL_WIDTH + rd_x);

	// small-image store
	always_ff @(posedge clk) begin
		if (wr_en)
			store_mem[wr_addr] <= pixel_in;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_s1 <= store_mem[rd_addr];
	end

	// weight and accumulate pipeline
	always_ff @(posedge clk) begin
		wt_s1   <= bius_pkg::WT_W'(bius_pkg::WT_W'(wa) * bius_pkg::WT_W'(wb));
		prod_s2 <= bius_pkg::ACC_W'(bius_pkg::ACC_W'(rd_data_s1) * bius_pkg::ACC_W'(wt_s1));
		if (state_q == S_CHECK)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + prod_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc)
						state_q <= (opcode == bius_pkg::OP_LOAD) ? S_FIN : S_CHECK;
				end
				S_CHECK: begin
					state_q <= interp_oob ? S_FIN : S_DIV;
				end
				S_DIV: begin
					tap_q <= '0;
					if (div_x_rsp.done)
						state_q <= S_READ;
				end
				S_READ: begin
					tap_q <= tap_q + 1'b1;
					if (tap_q == 2'd3)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (drained)
						state_q <= S_NORM;
				end
				S_NORM: begin
					if (div_x_rsp.done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_move)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q     <= col;
			row_q     <= row;
			res_pix_q <= '0;
			res_oor_q <= (opcode == bius_pkg::OP_LOAD) && load_oob;
		end
		if ((state_q == S_CHECK) && interp_oob)
			res_oor_q <= 1'b1;
		if ((state_q == S_DIV) && div_x_rsp.done) begin
			x1_q <= x1_n;
			y1_q <= y1_n;
			x2_q <= (x1_inc < w_eff) ? bius_pkg::XW'(x1_inc) : bius_pkg::XW'(w_eff - 1'b1);
			y2_q <= (y1_inc < h_eff) ? bius_pkg::YW'(y1_inc) : bius_pkg::YW'(h_eff - 1'b1);
			fx_q <= div_x_rsp.remainder[bius_pkg::SCALE_W-1:0];
			fy_q <= div_y_rsp.remainder[bius_pkg::SCALE_W-1:0];
			gx_q <= s_eff - div_x_rsp.remainder[bius_pkg::SCALE_W-1:0];
			gy_q <= s_eff - div_y_rsp.remainder[bius_pkg::SCALE_W-1:0];
		end
		if ((state_q == S_NORM) && div_x_rsp.done)
			res_pix_q <= div_x_rsp.quot[bius_pkg::PIX_W-1:0];
		if (fin_move) begin
			out_pix_q <= res_pix_q;
			out_oor_q <= res_oor_q;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_move)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid    = out_valid_q;
	assign pixel_out    = out_pix_q;
	assign out_of_range = out_oor_q;

endmodule

[hw/rtl/bius_div.sv]
// restoring divider, one quotient bit per cycle
module bius_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bius_pkg::div_req_t req,
	output bius_pkg::div_rsp_t rsp
);

	logic [bius_pkg::DIV_N-1:0]  quo_q;
	logic [bius_pkg::DIV_D-1:0]  rem_q;
	logic [bius_pkg::DIV_D-1:0]  div_q;
	logic [bius_pkg::DCNT_W-1:0] cnt_q;
	logic                        run_q;
	logic                        done_q;

	logic [bius_pkg::DIV_D:0]   shifted;
	logic [bius_pkg::DIV_D+1:0] diff;
	logic                       neg;

	assign shifted = {rem_q, quo_q[bius_pkg::DIV_N-1]};
	assign diff    = {1'b0, shifted} - {2'b00, div_q};
	assign neg     = diff[bius_pkg::DIV_D+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= bius_pkg::DCNT_W'(bius_pkg::DIV_N);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == bius_pkg::DCNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[bius_pkg::DIV_N-2:0], ~neg};
			rem_q <= neg ? shifted[bius_pkg::DIV_D-1:0] : diff[bius_pkg::DIV_D-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quot      = quo_q;
	assign rsp.remainder = rem_q;

endmodule
